// ===== hdl/ysrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ysrc_pkg
// Shared types and constants of the YUYV to RGB converter: register map,
// reset values, Q10 color coefficients and the pixel operand struct.
// ----------------------------------------------------------------------------
package ysrc_pkg;

    // register map
    localparam int CFG_INDEX_WIDTH = 2;
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FRAME_PIXELS = 2'd0,
        CFG_SYNC_WORD    = 2'd1
    } cfg_reg_t;

    localparam int FRAME_PIXELS_WIDTH = 17;
    localparam int WORD_WIDTH         = 16;
    localparam int CFG_DATA_WIDTH     = 17;

    localparam logic [FRAME_PIXELS_WIDTH-1:0] FRAME_PIXELS_RESET = 17'd19200;
    localparam logic [WORD_WIDTH-1:0]         SYNC_WORD_RESET    = 16'h55AA;

    // frame length bounds
    localparam logic [FRAME_PIXELS_WIDTH-1:0] MIN_FRAME_PIXELS = 17'd2;
    localparam logic [FRAME_PIXELS_WIDTH-1:0] MAX_FRAME_PIXELS = 17'd65536;

    // color math, Q10 fixed point
    localparam int COEF_FRAC_BITS = 10;
    localparam int SUM_WIDTH      = 21;
    localparam logic signed [11:0] COEF_RV = 12'sd1441;
    localparam logic signed [11:0] COEF_GU = 12'sd354;
    localparam logic signed [11:0] COEF_GV = 12'sd734;
    localparam logic signed [11:0] COEF_BU = 12'sd1822;
    localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;

    // operands of one pixel conversion
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
    } pixel_yuv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_rgb_t;

endpackage

// ===== hdl/ysrc_pixel_conv.sv =====
// ----------------------------------------------------------------------------
// ysrc_pixel_conv
// One YUV to RGB pixel conversion: constant multiplies in Q10, truncation and
// clamp of each channel to 0..255.
// ----------------------------------------------------------------------------
module ysrc_pixel_conv
    import ysrc_pkg::*;
(
    input  pixel_yuv_t yuv,
    output pixel_rgb_t rgb
);

    logic signed [8:0]           du;
    logic signed [8:0]           dv;
    logic signed [SUM_WIDTH-1:0] luma_q;
    logic signed [SUM_WIDTH-1:0] sum_r;
    logic signed [SUM_WIDTH-1:0] sum_g;
    logic signed [SUM_WIDTH-1:0] sum_b;

    function automatic logic [7:0] to_byte(input logic signed [SUM_WIDTH-1:0] s);
        logic [SUM_WIDTH-COEF_FRAC_BITS-1:0] q;
        q = s[SUM_WIDTH-1:COEF_FRAC_BITS];
        if (s[SUM_WIDTH-1])
            return 8'd0;
        else if (q > 255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

    // chroma offsets and scaled luma
    assign du     = $signed({1'b0, yuv.chroma_u}) - CHROMA_OFFSET;
    assign dv     = $signed({1'b0, yuv.chroma_v}) - CHROMA_OFFSET;
    assign luma_q = $signed({{(SUM_WIDTH-8-COEF_FRAC_BITS){1'b0}}, yuv.luma,
                             {COEF_FRAC_BITS{1'b0}}});

    // channel sums
    assign sum_r = luma_q + SUM_WIDTH'(COEF_RV * dv);
    assign sum_g = luma_q - SUM_WIDTH'(COEF_GU * du) - SUM_WIDTH'(COEF_GV * dv);
    assign sum_b = luma_q + SUM_WIDTH'(COEF_BU * du);

    // clamp to byte range
    assign rgb.red   = to_byte(sum_r);
    assign rgb.green = to_byte(sum_g);
    assign rgb.blue  = to_byte(sum_b);

endmodule

// ===== hdl/yuyv_sync_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// yuyv_sync_to_rgb_converter_top
// YUYV 4:2:2 stream to RGB888 pixels with frame sync word and frame end flag.
// ----------------------------------------------------------------------------
// The block takes one 16-bit word per cycle (luma in bits 7:0, chroma in bits
// 15:8, U and V alternating) and sustains that rate while out_stall is low:
// every pair of words yields two RGB pixels, which leave one per cycle from
// the output register. The pair register is the only point where the input
// can stall: a pair-completing word waits while the previous pair has not yet
// handed its second pixel to the output register. While searching, words other
// than the sync word are dropped; after sync the configured number of pixels,
// clamped to 2..65536 and rounded up to a whole pair, is taken and the last
// one carries end_of_frame.
module yuyv_sync_to_rgb_converter_top
    import ysrc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [WORD_WIDTH-1:0]      data_word,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    // pixel stream
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue,
    output logic                       last_of_run,
    output logic                       end_of_frame
);

    logic [FRAME_PIXELS_WIDTH-1:0] frame_pixels_reg;
    logic [WORD_WIDTH-1:0]         sync_word_reg;

    logic                          in_frame_reg;
    logic                          odd_phase_reg;
    logic [FRAME_PIXELS_WIDTH-1:0] pixel_index_reg;
    logic [7:0]                    held_luma_reg;
    logic [7:0]                    held_u_reg;

    logic                          pair_valid_reg;
    logic                          pix_sel_reg;
    logic [7:0]                    pair_y0_reg;
    logic [7:0]                    pair_y1_reg;
    logic [7:0]                    pair_u_reg;
    logic [7:0]                    pair_v_reg;
    logic                          pair_eof_reg;

    logic                          out_valid_reg;
    pixel_rgb_t                    rgb_reg;
    logic                          last_reg;
    logic                          eof_reg;

    logic                          in_fire;
    logic                          pair_load;
    logic                          out_load;
    logic                          pair_release;
    logic [FRAME_PIXELS_WIDTH-1:0] limit;
    logic [FRAME_PIXELS_WIDTH:0]   index_sum;
    logic                          frame_end;
    pixel_yuv_t                    conv_in;
    pixel_rgb_t                    conv_out;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
            sync_word_reg    <= SYNC_WORD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_PIXELS: frame_pixels_reg <= cfg_data;
                CFG_SYNC_WORD:    sync_word_reg    <= cfg_data[WORD_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // handshakes
    assign out_load     = pair_valid_reg && (!out_valid_reg || !out_stall);
    assign pair_release = out_load && pix_sel_reg;
    assign in_stall     = in_frame_reg && odd_phase_reg && pair_valid_reg && !pair_release;
    assign in_fire      = in_valid && !in_stall;
    assign pair_load    = in_fire && in_frame_reg && odd_phase_reg;

    // frame length limit and end test
    always_comb
    begin
        limit = frame_pixels_reg;
        if (limit < MIN_FRAME_PIXELS)
            limit = MIN_FRAME_PIXELS;
        if (limit > MAX_FRAME_PIXELS)
            limit = MAX_FRAME_PIXELS;
    end

    assign index_sum = {1'b0, pixel_index_reg} + (FRAME_PIXELS_WIDTH+1)'(2);
    assign frame_end = index_sum >= {1'b0, limit};

    // sync search and pair phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            odd_phase_reg   <= 1'b0;
            pixel_index_reg <= '0;
        end
        else if (in_fire)
        begin
            if (!in_frame_reg)
            begin
                if (data_word == sync_word_reg)
                begin
                    in_frame_reg    <= 1'b1;
                    odd_phase_reg   <= 1'b0;
                    pixel_index_reg <= '0;
                end
            end
            else if (!odd_phase_reg)
            begin
                odd_phase_reg <= 1'b1;
            end
            else
            begin
                odd_phase_reg <= 1'b0;
                if (frame_end)
                begin
                    in_frame_reg    <= 1'b0;
                    pixel_index_reg <= '0;
                end
                else
                begin
                    pixel_index_reg <= index_sum[FRAME_PIXELS_WIDTH-1:0];
                end
            end
        end
    end

    // held luma and U of the first word
    always_ff @(posedge clk)
    begin
        if (in_fire && in_frame_reg && !odd_phase_reg)
        begin
            held_luma_reg <= data_word[7:0];
            held_u_reg    <= data_word[15:8];
        end
    end

    // pair register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            pix_sel_reg    <= 1'b0;
        end
        else
        begin
            if (pair_load)
            begin
                pair_valid_reg <= 1'b1;
                pix_sel_reg    <= 1'b0;
            end
            else if (pair_release)
            begin
                pair_valid_reg <= 1'b0;
                pix_sel_reg    <= 1'b0;
            end
            else if (out_load)
            begin
                pix_sel_reg <= 1'b1;
            end
        end
    end

    // pair payload
    always_ff @(posedge clk)
    begin
        if (pair_load)
        begin
            pair_y0_reg  <= held_luma_reg;
            pair_y1_reg  <= data_word[7:0];
            pair_u_reg   <= held_u_reg;
            pair_v_reg   <= data_word[15:8];
            pair_eof_reg <= frame_end;
        end
    end

    // color conversion of the selected pixel
    assign conv_in.luma     = pix_sel_reg ? pair_y1_reg : pair_y0_reg;
    assign conv_in.chroma_u = pair_u_reg;
    assign conv_in.chroma_v = pair_v_reg;

    ysrc_pixel_conv u_conv (
        .yuv (conv_in),
        .rgb (conv_out)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rgb_reg  <= conv_out;
            last_reg <= pix_sel_reg;
            eof_reg  <= pix_sel_reg && pair_eof_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = rgb_reg.red;
    assign green        = rgb_reg.green;
    assign blue         = rgb_reg.blue;
    assign last_of_run  = last_reg;
    assign end_of_frame = eof_reg;

endmodule

// ===== tb/yuyv_rgb_checker.sv =====
// ----------------------------------------------------------------------------
// yuyv_rgb_checker
// Watches the word, register and pixel channels of the YUYV to RGB converter.
// It tracks frame sync and pixel pairs on its own, converts each completed
// pair to two RGB pixels in Q10 and compares every pixel beat field by field.
// ----------------------------------------------------------------------------
module yuyv_rgb_checker
    import ysrc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [WORD_WIDTH-1:0]      data_word,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic                       last_of_run,
    input  logic                       end_of_frame,
    output int unsigned                fail_count,
    output int unsigned                pixels_pending,
    output int unsigned                pixels_checked,
    output int unsigned                frames_ended
);
    timeunit 1ns;
    timeprecision 1ps;

    // 1.4075, 0.3455, 0.7169 and 1.7790 scaled by 2^10, rounded
    localparam int FRAC_BITS  = 10;
    localparam int RV_Q10     = 1441;
    localparam int GU_Q10     = 354;
    localparam int GV_Q10     = 734;
    localparam int BU_Q10     = 1822;
    localparam int LIMIT_LOW  = 2;
    localparam int LIMIT_HIGH = 65536;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_run;
        logic       end_of_frame;
    } rgb_beat_t;

    // shadow registers and pair tracking
    logic [FRAME_PIXELS_WIDTH-1:0] frame_pixels_reg = FRAME_PIXELS_RESET;
    logic [WORD_WIDTH-1:0]         sync_word_reg    = SYNC_WORD_RESET;
    bit                            in_frame         = 1'b0;
    bit                            odd_word         = 1'b0;
    int unsigned                   pixel_index      = 0;
    logic [7:0]                    held_luma        = '0;
    logic [7:0]                    held_u           = '0;

    rgb_beat_t   predicted_pixels[$];
    int unsigned fail_total    = 0;
    int unsigned checked_total = 0;
    int unsigned eof_total     = 0;

    // truncate a Q10 sum to a byte, clamped at both ends
    function automatic logic [7:0] saturate_q10(input int s);
        int q;
        if (s < 0)
            return 8'd0;
        q = s >>> FRAC_BITS;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic rgb_beat_t yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                             input logic [7:0] v, input logic second,
                                             input logic eof);
        int        luma_q;
        int        du;
        int        dv;
        rgb_beat_t p;
        luma_q = int'(y) <<< FRAC_BITS;
        du     = int'(u) - 128;
        dv     = int'(v) - 128;
        p.red          = saturate_q10(luma_q + RV_Q10 * dv);
        p.green        = saturate_q10(luma_q - GU_Q10 * du - GV_Q10 * dv);
        p.blue         = saturate_q10(luma_q + BU_Q10 * du);
        p.last_of_run  = second;
        p.end_of_frame = eof;
        return p;
    endfunction

    // advance the frame tracker by one accepted word
    task automatic convert_word(input logic [WORD_WIDTH-1:0] w);
        int unsigned frame_limit;
        logic        eof;
        if (!in_frame)
        begin
            if (w == sync_word_reg)
            begin
                in_frame    = 1'b1;
                pixel_index = 0;
                odd_word    = 1'b0;
            end
        end
        else if (!odd_word)
        begin
            held_luma = w[7:0];
            held_u    = w[15:8];
            odd_word  = 1'b1;
        end
        else
        begin
            frame_limit = frame_pixels_reg;
            if (frame_limit < LIMIT_LOW)
                frame_limit = LIMIT_LOW;
            if (frame_limit > LIMIT_HIGH)
                frame_limit = LIMIT_HIGH;
            eof = (pixel_index + 2 >= frame_limit);
            predicted_pixels.push_back(yuv_to_rgb(held_luma, held_u, w[15:8], 1'b0, 1'b0));
            predicted_pixels.push_back(yuv_to_rgb(w[7:0], held_u, w[15:8], 1'b1, eof));
            odd_word = 1'b0;
            if (eof)
            begin
                in_frame    = 1'b0;
                pixel_index = 0;
            end
            else
            begin
                pixel_index = (pixel_index + 2) & 32'h1FFFF;
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            fail_total++;
            $display("%0t: pixel %0d %s mismatch, expected %0d, actual %0d",
                     $realtime, checked_total, field, want, got);
        end
    endtask

    // register writes first, then words, then pixel beats
    always @(posedge clk or negedge rst_n)
    begin
        rgb_beat_t want;
        if (!rst_n)
        begin
            frame_pixels_reg = FRAME_PIXELS_RESET;
            sync_word_reg    = SYNC_WORD_RESET;
            in_frame         = 1'b0;
            odd_word         = 1'b0;
            pixel_index      = 0;
            held_luma        = '0;
            held_u           = '0;
            predicted_pixels.delete();
            fail_count     <= 0;
            pixels_pending <= 0;
            pixels_checked <= 0;
            frames_ended   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRAME_PIXELS: frame_pixels_reg = cfg_data;
                    CFG_SYNC_WORD:    sync_word_reg    = cfg_data[WORD_WIDTH-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
                convert_word(data_word);
            if (out_valid && !out_stall)
            begin
                if (predicted_pixels.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected pixel, expected none, actual %0d/%0d/%0d",
                             $realtime, red, green, blue);
                end
                else
                begin
                    want = predicted_pixels.pop_front();
                    compare_field("red", want.red, red);
                    compare_field("green", want.green, green);
                    compare_field("blue", want.blue, blue);
                    compare_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, last_of_run});
                    compare_field("end_of_frame", {7'd0, want.end_of_frame},
                                  {7'd0, end_of_frame});
                    if (want.end_of_frame)
                        eof_total++;
                    checked_total++;
                end
            end
            fail_count     <= fail_total;
            pixels_pending <= predicted_pixels.size();
            pixels_checked <= checked_total;
            frames_ended   <= eof_total;
        end
    end

endmodule

// ===== tb/yuyv_sync_to_rgb_converter_top_test.sv =====
// ----------------------------------------------------------------------------
// yuyv_sync_to_rgb_converter_top_test
// Drives words and register writes into the YUYV to RGB converter: directed
// corner cases, a long output hold, random frames under three idle patterns
// and a frame with its length register above the cap. The checker beside the
// block compares.
// ----------------------------------------------------------------------------
module yuyv_sync_to_rgb_converter_top_test
    import ysrc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_B = 2'd3;
    localparam int          SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS   = 180;
    localparam int          HOLD_CYCLES   = 200;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [WORD_WIDTH-1:0]      data_word;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       out_valid;
    logic                       out_stall;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
    logic                       last_of_run;
    logic                       end_of_frame;
    int unsigned                fail_count;
    int unsigned                pixels_pending;
    int unsigned                pixels_checked;
    int unsigned                frames_ended;

    int          send_idle_pct = 12;
    int          recv_idle_pct = 62;
    int unsigned hold_requests = 0;
    int unsigned random_items  = 0;
    int unsigned cfg_writes    = 0;
    logic [FRAME_PIXELS_WIDTH-1:0] cur_frame_pixels = FRAME_PIXELS_RESET;
    logic [WORD_WIDTH-1:0]         cur_sync         = SYNC_WORD_RESET;

    yuyv_sync_to_rgb_converter_top uut (.*);
    yuyv_rgb_checker               pixel_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        int          hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // words the frame takes after sync: clamped limit rounded up to a pair
    function automatic int unsigned frame_words(input logic [FRAME_PIXELS_WIDTH-1:0] fp);
        int unsigned lim;
        lim = fp;
        if (lim < 2)
            lim = 2;
        if (lim > 65536)
            lim = 65536;
        return ((lim + 1) / 2) * 2;
    endfunction

    // idle cycles come one at a time at the sender's idle rate
    task automatic send_word(input logic [WORD_WIDTH-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_word <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop offering words and let every pending pixel drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_FRAME_PIXELS)
            cur_frame_pixels = val;
        else if (idx == CFG_SYNC_WORD)
            cur_sync = val[WORD_WIDTH-1:0];
    endtask

    // optional noise, the marker, then a full or cut-short frame of random words
    task automatic send_frame(input bit complete);
        int unsigned           n;
        logic [WORD_WIDTH-1:0] w;
        repeat ($urandom_range(0, 2))
        begin
            do
                w = 16'($urandom);
            while (w == cur_sync);
            send_word(w);
        end
        send_word(cur_sync);
        n = frame_words(cur_frame_pixels);
        if (!complete)
            n = $urandom_range(0, n - 1);
        repeat (n) send_word(16'($urandom));
        random_items += n;
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int unsigned target);
        int unsigned start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = random_items;
        while (random_items - start < target)
        begin
            if ($urandom_range(3) == 0)
                write_register(CFG_FRAME_PIXELS,
                               17'($urandom_range(0, ($urandom_range(15) == 0) ? 64 : 24)));
            if ($urandom_range(7) == 0)
                write_register(CFG_SYNC_WORD, 17'($urandom));
            send_frame($urandom_range(9) != 0);
        end
    endtask

    task automatic run_directed();
        // reset settings: a stray word, the default marker, extreme pairs
        send_word(16'h1234);
        send_word(16'h55AA);
        send_word(16'h0000);
        send_word(16'h00FF);
        send_word(16'hFFFF);
        send_word(16'hFF00);
        send_word(16'h8080);
        send_word(16'h8080);
        // marker inside a frame is plain pixel data
        send_word(16'h55AA);
        send_word(16'h55AA);
        // shrink the frame mid-frame and poke unmapped indexes
        write_register(CFG_FRAME_PIXELS, 17'd0);
        write_register(CFG_UNMAPPED_A, 17'h1FFFF);
        write_register(CFG_UNMAPPED_B, 17'h00000);
        send_word(16'hA5C3);
        send_word(16'h3C7E);
        // marker of zero, bit 16 of the write data must be dropped
        write_register(CFG_SYNC_WORD, 17'h10000);
        send_word(16'h0001);
        send_word(16'h0000);
        send_word(16'h7F80);
        send_word(16'h807F);
        // length one is raised to a single pair
        write_register(CFG_FRAME_PIXELS, 17'd1);
        send_word(16'h0000);
        send_word(16'h40C0);
        send_word(16'hC040);
        // odd length ends on the pair past the limit
        write_register(CFG_FRAME_PIXELS, 17'd3);
        write_register(CFG_SYNC_WORD, 17'h0FFFF);
        send_word(16'hFFFF);
        send_word(16'h1F2E);
        send_word(16'hE0D1);
        send_word(16'h6A95);
        send_word(16'h956A);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_word = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_PIXELS;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // long output hold while words keep coming, so the input backs up
        write_register(CFG_FRAME_PIXELS, 17'd400);
        write_register(CFG_SYNC_WORD, 17'($urandom));
        send_word(cur_sync);
        hold_requests++;
        repeat (400) send_word(16'($urandom));

        run_phase(12, 62, PHASE_ITEMS);
        run_phase(62, 12, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        // length register above the cap, then a short limit closes the frame
        write_register(CFG_FRAME_PIXELS, 17'h1FFFF);
        send_word(cur_sync);
        repeat (40) send_word(16'($urandom));
        write_register(CFG_FRAME_PIXELS, 17'd2);
        send_word(16'($urandom));
        send_word(16'($urandom));

        wait_idle();
        $display("covered %0d pixels in %0d ended frames with %0d register writes",
                 pixels_checked, frames_ended, cfg_writes);
        $display("frame limits from 2 to 64 pixels and above the cap, idling on both sides, "
                 , "long output hold");
        if (fail_count == 0 && pixels_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== yuyv_sync_to_rgb_converter_top.f =====
hdl/ysrc_pkg.sv
hdl/ysrc_pixel_conv.sv
hdl/yuyv_sync_to_rgb_converter_top.sv
tb/yuyv_rgb_checker.sv
tb/yuyv_sync_to_rgb_converter_top_test.sv
